// ----- src/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg
// types, constants and the arctangent table shared by the polar to cartesian
// converter
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int ANG_W   = 16;
	localparam int DIST_W  = 16;
	localparam int COORD_W = 17;
	localparam int IDX_W   = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// cordic datapath widths
	localparam int CW = 36;
	localparam int ZW = 33;

	localparam int GAIN_W = 30;
	localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

	localparam logic [ANG_W-1:0] ANGLE_OFFSET_RST = 16'd25941;
	localparam logic             NEGATE_X_RST     = 1'b1;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 17'sd65535;
	localparam logic signed [COORD_W-1:0] COORD_MIN = -17'sd65535;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEGATE_X     = 1'd1;

	typedef struct packed {
		logic valid;
		logic drop;
		logic last;
	} meta_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_pos;
		logic signed [COORD_W-1:0] y_pos;
		logic [IDX_W-1:0]          point_index;
		logic                      is_end;
	} point_t;

	typedef struct packed {
		logic [1:0] count;
		point_t     first;
		point_t     second;
	} push_t;

	function automatic logic [31:0] atan_turn(input int step);
		logic [31:0] v;
		case (step)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ----- src/lpc_sample_if.sv -----
// ----------------------------------------------------------------------------
// lpc_sample_if
// sample channel: angle, distance and end-of-scan mark
// ----------------------------------------------------------------------------
interface lpc_sample_if;
	logic                        valid;
	logic                        ready;
	logic [lpc_pkg::ANG_W-1:0]   angle;
	logic [lpc_pkg::DIST_W-1:0]  distance;
	logic                        scan_last;

	modport source (output valid, output angle, output distance, output scan_last,
		input ready);
	modport sink (input valid, input angle, input distance, input scan_last,
		output ready);
endinterface

// ----- src/lpc_point_if.sv -----
// ----------------------------------------------------------------------------
// lpc_point_if
// point channel: cartesian coordinates, index within the scan and end mark
// ----------------------------------------------------------------------------
interface lpc_point_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lpc_pkg::COORD_W-1:0]   x_pos;
	logic signed [lpc_pkg::COORD_W-1:0]   y_pos;
	logic [lpc_pkg::IDX_W-1:0]            point_index;
	logic                                 is_end;

	modport source (output valid, output x_pos, output y_pos, output point_index,
		output is_end, input ready);
	modport sink (input valid, input x_pos, input y_pos, input point_index,
		input is_end, output ready);
endinterface

// ----- src/lpc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lpc_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface lpc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lpc_pkg::CFG_IDX_W-1:0]      index;
	logic [lpc_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/lpc_cell.sv -----
// ----------------------------------------------------------------------------
// lpc_cell
// one cordic rotation step, registered
// ----------------------------------------------------------------------------
module lpc_cell #(
	parameter int STEP = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  lpc_pkg::meta_t                    meta_i,
	input  logic signed [lpc_pkg::CW-1:0]     x_i,
	input  logic signed [lpc_pkg::CW-1:0]     y_i,
	input  logic signed [lpc_pkg::ZW-1:0]     z_i,
	output lpc_pkg::meta_t                    meta_o,
	output logic signed [lpc_pkg::CW-1:0]     x_o,
	output logic signed [lpc_pkg::CW-1:0]     y_o,
	output logic signed [lpc_pkg::ZW-1:0]     z_o
);

	localparam logic [31:0] ATAN = lpc_pkg::atan_turn(STEP);

	logic signed [lpc_pkg::CW-1:0] dx;
	logic signed [lpc_pkg::CW-1:0] dy;
	logic signed [lpc_pkg::ZW-1:0] da;
	logic signed [lpc_pkg::CW-1:0] x_d;
	logic signed [lpc_pkg::CW-1:0] y_d;
	logic signed [lpc_pkg::ZW-1:0] z_d;

	lpc_pkg::meta_t                meta_s1;
	logic signed [lpc_pkg::CW-1:0] x_s1;
	logic signed [lpc_pkg::CW-1:0] y_s1;
	logic signed [lpc_pkg::ZW-1:0] z_s1;

	assign dx = y_i >>> STEP;
	assign dy = x_i >>> STEP;
	assign da = $signed({{(lpc_pkg::ZW-32){1'b0}}, ATAN});

	always_comb begin
		if (!z_i[lpc_pkg::ZW-1]) begin
			x_d = x_i - dx;
			y_d = y_i + dy;
			z_d = z_i - da;
		end else begin
			x_d = x_i + dx;
			y_d = y_i - dy;
			z_d = z_i + da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1 <= meta_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_d;
			y_s1 <= y_d;
			z_s1 <= z_d;
		end
	end

	assign meta_o = meta_s1;
	assign x_o    = x_s1;
	assign y_o    = y_s1;
	assign z_o    = z_s1;

endmodule

// ----- src/lpc_scan.sv -----
// ----------------------------------------------------------------------------
// lpc_scan
// rounding and saturation, then the held point and the per-scan index count
// ----------------------------------------------------------------------------
module lpc_scan #(
	parameter int SCAN_POINTS = 8192
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              negate_x,
	input  lpc_pkg::meta_t                    meta_i,
	input  logic signed [lpc_pkg::CW-1:0]     x_i,
	input  logic signed [lpc_pkg::CW-1:0]     y_i,
	output lpc_pkg::push_t                    push
);

	localparam int VCW = $clog2(SCAN_POINTS + 1);
	localparam int IW  = lpc_pkg::IDX_W;
	localparam int RW  = lpc_pkg::CW + 1 - 16;
	localparam int KW  = lpc_pkg::COORD_W;

	function automatic logic signed [KW-1:0] round_sat(input logic signed [lpc_pkg::CW-1:0] v);
		logic signed [lpc_pkg::CW:0] s;
		logic signed [RW-1:0]        r;
		logic signed [KW-1:0]        o;
		s = $signed({v[lpc_pkg::CW-1], v}) + $signed((lpc_pkg::CW+1)'(32768));
		r = RW'(s >>> 16);
		if (r > $signed(RW'(lpc_pkg::COORD_MAX)))
			o = lpc_pkg::COORD_MAX;
		else if (r < $signed(RW'(lpc_pkg::COORD_MIN)))
			o = lpc_pkg::COORD_MIN;
		else
			o = KW'(r);
		return o;
	endfunction

	lpc_pkg::meta_t        meta_s1;
	logic signed [KW-1:0]  rx_s1;
	logic signed [KW-1:0]  ry_s1;

	logic signed [KW-1:0]  held_x_q;
	logic signed [KW-1:0]  held_y_q;
	logic                  held_valid_q;
	logic [VCW-1:0]        valid_count_q;

	logic signed [KW-1:0]  nx;
	logic [VCW-1:0]        idx_new;
	logic [VCW-1:0]        idx_held;
	lpc_pkg::point_t       held_pt;
	lpc_pkg::point_t       new_pt;
	lpc_pkg::push_t        push_d;
	logic                  held_valid_d;
	logic [VCW-1:0]        valid_count_d;
	logic                  take_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1 <= meta_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= round_sat(x_i);
			ry_s1 <= round_sat(y_i);
		end
	end

	assign nx       = negate_x ? -rx_s1 : rx_s1;
	assign idx_new  = (valid_count_q < VCW'(SCAN_POINTS)) ? valid_count_q
		: VCW'(SCAN_POINTS - 1);
	assign idx_held = valid_count_q - 1'b1;

	always_comb begin
		held_pt.x_pos       = held_x_q;
		held_pt.y_pos       = held_y_q;
		held_pt.point_index = IW'(idx_held);
		held_pt.is_end      = 1'b0;
		new_pt.x_pos        = nx;
		new_pt.y_pos        = ry_s1;
		new_pt.point_index  = IW'(idx_new);
		new_pt.is_end       = 1'b1;

		push_d        = '0;
		push_d.first  = held_pt;
		push_d.second = new_pt;
		held_valid_d  = held_valid_q;
		valid_count_d = valid_count_q;
		take_new      = 1'b0;

		if (meta_s1.valid) begin
			if (meta_s1.drop) begin
				if (meta_s1.last) begin
					if (held_valid_q) begin
						push_d.count        = 2'd1;
						push_d.first.is_end = 1'b1;
					end
					held_valid_d  = 1'b0;
					valid_count_d = '0;
				end
			end else begin
				if (meta_s1.last) begin
					if (held_valid_q) begin
						push_d.count = 2'd2;
					end else begin
						push_d.count = 2'd1;
						push_d.first = new_pt;
					end
					held_valid_d  = 1'b0;
					valid_count_d = '0;
				end else begin
					push_d.count = held_valid_q ? 2'd1 : 2'd0;
					take_new     = 1'b1;
					held_valid_d = 1'b1;
					if (valid_count_q < VCW'(SCAN_POINTS))
						valid_count_d = valid_count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			valid_count_q <= '0;
		end else if (en) begin
			held_valid_q  <= held_valid_d;
			valid_count_q <= valid_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && take_new) begin
			held_x_q <= nx;
			held_y_q <= ry_s1;
		end
	end

	always_comb begin
		push = push_d;
		if (!en)
			push.count = 2'd0;
	end

endmodule

// ----- src/lpc_fifo.sv -----
// ----------------------------------------------------------------------------
// lpc_fifo
// point queue, takes up to two items per cycle and gives one while the sink is ready
// ----------------------------------------------------------------------------
module lpc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  lpc_pkg::push_t      push,
	output logic                room2,
	lpc_point_if.source         points
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	lpc_pkg::point_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            pop;
	lpc_pkg::point_t head;

	assign pop   = points.valid && points.ready;
	assign room2 = count_q <= CNTW'(DEPTH - 2);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.count);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CNTW'(push.count) - CNTW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wr_ptr_q + 1'b1] <= push.second;
	end

	assign points.valid       = count_q != '0;
	assign points.x_pos       = head.x_pos;
	assign points.y_pos       = head.y_pos;
	assign points.point_index = head.point_index;
	assign points.is_end      = head.is_end;

endmodule

// ----- src/lidar_polar_to_cartesian.sv -----
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian
// range samples to cartesian points through a chain of cordic rotation cells
// a point passes the input registers, cordic cells, scan register and queue after the
// sample that releases it (the next nonzero-distance or scan-end sample, or its own sample
// when that one ends the scan); throughput: one sample per cycle; the output queue stalls
// intake while it has fewer than two free entries
// reset clears the held point, the scan count and the queue; registers to defaults
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian #(
	parameter int SCAN_POINTS  = 8192,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lpc_sample_if.sink  samples,
	lpc_point_if.source points,
	lpc_cfg_if.sink     cfg
);

	localparam int CW = lpc_pkg::CW;
	localparam int ZW = lpc_pkg::ZW;
	localparam int PRODW = lpc_pkg::DIST_W + lpc_pkg::GAIN_W;

	logic [lpc_pkg::ANG_W-1:0] angle_offset_q;
	logic                      negate_x_q;

	logic                      en;
	logic                      room2;
	lpc_pkg::push_t            push;

	logic [lpc_pkg::ANG_W-1:0] phase;
	logic                      flip;
	logic [lpc_pkg::ANG_W-1:0] phase_f;
	logic [PRODW-1:0]          prod;
	lpc_pkg::meta_t            meta_in;

	lpc_pkg::meta_t            meta_s1;
	logic [31:0]               mag_s1;
	logic                      flip_s1;
	logic signed [ZW-1:0]      z_s1;

	lpc_pkg::meta_t            meta_s2;
	logic signed [CW-1:0]      x_s2;
	logic signed [ZW-1:0]      z_s2;
	logic signed [CW-1:0]      mag_ext;

	lpc_pkg::meta_t            meta_c [CORDIC_STEPS+1];
	logic signed [CW-1:0]      x_c    [CORDIC_STEPS+1];
	logic signed [CW-1:0]      y_c    [CORDIC_STEPS+1];
	logic signed [ZW-1:0]      z_c    [CORDIC_STEPS+1];

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_offset_q <= lpc_pkg::ANGLE_OFFSET_RST;
			negate_x_q     <= lpc_pkg::NEGATE_X_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lpc_pkg::CFG_ANGLE_OFFSET: angle_offset_q <= cfg.data;
				lpc_pkg::CFG_NEGATE_X:     negate_x_q     <= cfg.data[0];
			endcase
		end
	end

	assign en            = room2;
	assign samples.ready = en;

	// phase, half-turn fold and gain-corrected start magnitude
	assign phase   = samples.angle + angle_offset_q;
	assign flip    = phase[15] ^ phase[14];
	assign phase_f = {phase[15] ^ flip, phase[14:0]};
	assign prod    = PRODW'(samples.distance) * PRODW'(lpc_pkg::GAIN_Q30);

	always_comb begin
		meta_in.valid = samples.valid;
		meta_in.drop  = samples.distance == '0;
		meta_in.last  = samples.scan_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
		end else if (en) begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
		end
	end

	assign mag_ext = $signed({{(CW-32){1'b0}}, mag_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= prod[PRODW-1:14];
			flip_s1 <= flip;
			z_s1    <= $signed({phase_f[15], phase_f, 16'd0});
			x_s2    <= flip_s1 ? -mag_ext : mag_ext;
			z_s2    <= z_s1;
		end
	end

	assign meta_c[0] = meta_s2;
	assign x_c[0]    = x_s2;
	assign y_c[0]    = '0;
	assign z_c[0]    = z_s2;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		lpc_cell #(
			.STEP (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.meta_i (meta_c[i]),
			.x_i    (x_c[i]),
			.y_i    (y_c[i]),
			.z_i    (z_c[i]),
			.meta_o (meta_c[i+1]),
			.x_o    (x_c[i+1]),
			.y_o    (y_c[i+1]),
			.z_o    (z_c[i+1])
		);
	end

	lpc_scan #(
		.SCAN_POINTS (SCAN_POINTS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.negate_x (negate_x_q),
		.meta_i   (meta_c[CORDIC_STEPS]),
		.x_i      (x_c[CORDIC_STEPS]),
		.y_i      (y_c[CORDIC_STEPS]),
		.push     (push)
	);

	lpc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room2  (room2),
		.points (points)
	);

endmodule
